// File: rtl/u8n1_pkg.sv
// ---------------------------------------------------------------------------
// u8n1_pkg
// Shared types and constants of the 8N1 UART transceiver core.
// ---------------------------------------------------------------------------
`default_nettype none

package u8n1_pkg;

  localparam int unsigned DATA_BITS_DEFAULT = 8;
  localparam int unsigned TPB_W             = 16;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned IN_TDATA_W        = 16;
  localparam int unsigned OUT_TDATA_W       = 16;

  localparam logic [TPB_W-1:0] TICKS_PER_BIT_RESET = 16'd1667;

  typedef enum logic [1:0] {
    TX_IDLE  = 2'd0,
    TX_START = 2'd1,
    TX_DATA  = 2'd2,
    TX_STOP  = 2'd3
  } tx_phase_t;

  typedef enum logic [1:0] {
    RX_WAIT_HIGH = 2'd0,
    RX_WAIT_EDGE = 2'd1,
    RX_FIRST     = 2'd2,
    RX_BITS      = 2'd3
  } rx_phase_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_out_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_out_t;

endpackage

`default_nettype wire

// File: rtl/uart_8n1_transceiver_core.sv
// ---------------------------------------------------------------------------
// uart_8n1_transceiver_core
// 8N1 UART transmitter and receiver; each input transaction is one line tick.
//
//   channel | direction | tdata fields (low bit up)
//   in_     | slave     | rx_line[0], tx_start[1], tx_byte[9:2]
//   out_    | master    | tx_line[0], tx_busy[1], rx_valid[2], rx_byte[10:3]
//   cfg_    | write     | ticks_per_bit[15:0]
//
// One transaction per cycle while out_tready is high; its result is in the
// output register on the next cycle. Transmit and receive state advance
// only on accepted input. A held result does not block input while
// out_tready is high. Reset is synchronous; ticks_per_bit resets to 1667.
// ---------------------------------------------------------------------------
`default_nettype none

module uart_8n1_transceiver_core #(
  parameter int unsigned DATA_BITS = u8n1_pkg::DATA_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // rx_line[0], tx_start[1], tx_byte[9:2], zero fill
  input  wire logic [u8n1_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // tx_line[0], tx_busy[1], rx_valid[2], rx_byte[10:3], zero fill
  output logic [u8n1_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [u8n1_pkg::TPB_W-1:0]          cfg_wr_data
);

  logic [u8n1_pkg::TPB_W-1:0]       tpb_r;
  logic [u8n1_pkg::TPB_W-1:0]       period;
  logic                             accept;
  logic                             out_valid_r;
  logic [u8n1_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  u8n1_pkg::tx_out_t                tx_res;
  u8n1_pkg::rx_out_t                rx_res;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign period    = (tpb_r == '0) ? u8n1_pkg::TPB_W'(1) : tpb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r <= u8n1_pkg::TICKS_PER_BIT_RESET;
    end else if (cfg_wr_en) begin
      tpb_r <= cfg_wr_data;
    end
  end

  u8n1_tx #(
    .DATA_BITS (DATA_BITS)
  ) u_tx (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick    (accept),
    .period  (period),
    .start   (in_tdata[1]),
    .tx_byte (in_tdata[9:2]),
    .res     (tx_res)
  );

  u8n1_rx #(
    .DATA_BITS (DATA_BITS)
  ) u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick    (accept),
    .period  (period),
    .rx_line (in_tdata[0]),
    .res     (rx_res)
  );

  assign out_data_nxt = {5'b00000, rx_res.data, rx_res.valid, tx_res.busy, tx_res.line};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/u8n1_tx.sv
// ---------------------------------------------------------------------------
// u8n1_tx
// Transmitter: start bit, data bits LSB first, stop bit; one tick per enable.
// ---------------------------------------------------------------------------
`default_nettype none

module u8n1_tx #(
  parameter int unsigned DATA_BITS = u8n1_pkg::DATA_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        tick,
  input  wire logic [u8n1_pkg::TPB_W-1:0]  period,
  input  wire logic                        start,
  input  wire logic [u8n1_pkg::BYTE_W-1:0] tx_byte,
  output u8n1_pkg::tx_out_t                res
);

  localparam int unsigned CNT_W = $clog2(DATA_BITS + 1);

  u8n1_pkg::tx_phase_t              phase_r, phase_nxt, phase_l;
  logic [u8n1_pkg::BYTE_W-1:0]      shift_r, shift_nxt, shift_l;
  logic [CNT_W-1:0]                 count_r, count_nxt, count_l, count_inc;
  logic [u8n1_pkg::TPB_W-1:0]       timer_r, timer_nxt, timer_l, timer_inc;
  logic                             load;
  logic                             expire;

  always_comb begin
    load      = (phase_r == u8n1_pkg::TX_IDLE) && start;
    phase_l   = load ? u8n1_pkg::TX_START : phase_r;
    shift_l   = load ? tx_byte : shift_r;
    count_l   = load ? '0 : count_r;
    timer_l   = load ? '0 : timer_r;
    timer_inc = timer_l + 1'b1;
    count_inc = count_l + 1'b1;
    expire    = (timer_inc >= period) || (timer_inc == '0);

    phase_nxt = phase_l;
    shift_nxt = shift_l;
    count_nxt = count_l;
    timer_nxt = timer_l;
    res.line  = 1'b1;
    res.busy  = 1'b0;

    if (phase_l != u8n1_pkg::TX_IDLE) begin
      res.busy  = 1'b1;
      timer_nxt = expire ? '0 : timer_inc;
      case (phase_l)
        u8n1_pkg::TX_START: begin
          res.line = 1'b0;
          if (expire) begin
            phase_nxt = u8n1_pkg::TX_DATA;
            count_nxt = '0;
          end
        end
        u8n1_pkg::TX_DATA: begin
          res.line = shift_l[0];
          if (expire) begin
            shift_nxt = shift_l >> 1;
            count_nxt = count_inc;
            if (count_inc >= CNT_W'(DATA_BITS)) begin
              phase_nxt = u8n1_pkg::TX_STOP;
            end
          end
        end
        default: begin
          res.line = 1'b1;
          if (expire) begin
            phase_nxt = u8n1_pkg::TX_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= u8n1_pkg::TX_IDLE;
      shift_r <= '0;
      count_r <= '0;
      timer_r <= '0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/u8n1_rx.sv
// ---------------------------------------------------------------------------
// u8n1_rx
// Receiver: edge detect, 1.5 bit wait, mid-bit sampling LSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module u8n1_rx #(
  parameter int unsigned DATA_BITS = u8n1_pkg::DATA_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       tick,
  input  wire logic [u8n1_pkg::TPB_W-1:0] period,
  input  wire logic                       rx_line,
  output u8n1_pkg::rx_out_t               res
);

  localparam int unsigned CNT_W   = $clog2(DATA_BITS + 1);
  localparam int unsigned TIMER_W = u8n1_pkg::TPB_W + 1;

  u8n1_pkg::rx_phase_t          phase_r, phase_nxt;
  logic [u8n1_pkg::BYTE_W-1:0]  shift_r, shift_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [TIMER_W-1:0]           timer_r, timer_nxt, timer_inc, first_thr, bit_thr;
  logic                         take;

  always_comb begin
    timer_inc = timer_r + 1'b1;
    bit_thr   = {1'b0, period};
    first_thr = {1'b0, period} + {2'b00, period[u8n1_pkg::TPB_W-1:1]};

    phase_nxt = phase_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    timer_nxt = timer_r;
    take      = 1'b0;
    res.valid = 1'b0;

    case (phase_r)
      u8n1_pkg::RX_WAIT_HIGH: begin
        if (rx_line) begin
          phase_nxt = u8n1_pkg::RX_WAIT_EDGE;
        end
      end
      u8n1_pkg::RX_WAIT_EDGE: begin
        if (!rx_line) begin
          phase_nxt = u8n1_pkg::RX_FIRST;
          timer_nxt = '0;
          shift_nxt = '0;
          count_nxt = '0;
        end
      end
      u8n1_pkg::RX_FIRST: begin
        timer_nxt = timer_inc;
        if (timer_inc >= first_thr) begin
          timer_nxt = '0;
          take      = 1'b1;
          phase_nxt = u8n1_pkg::RX_BITS;
        end
      end
      default: begin
        timer_nxt = timer_inc;
        if (timer_inc >= bit_thr) begin
          timer_nxt = '0;
          take      = 1'b1;
        end
      end
    endcase

    if (take) begin
      if ((32'(count_r) < u8n1_pkg::BYTE_W) && rx_line) begin
        shift_nxt[count_r[2:0]] = 1'b1;
      end
      count_nxt = count_r + 1'b1;
    end

    if ((phase_nxt == u8n1_pkg::RX_BITS) && (count_nxt >= CNT_W'(DATA_BITS))) begin
      res.valid = 1'b1;
      phase_nxt = u8n1_pkg::RX_WAIT_HIGH;
      count_nxt = '0;
      timer_nxt = '0;
    end

    res.data = shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= u8n1_pkg::RX_WAIT_HIGH;
      shift_r <= '0;
      count_r <= '0;
      timer_r <= '0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

`default_nettype wire
